### hw/rtl/tgs_pkg.sv
`default_nettype none

package tgs_pkg;

    localparam int MAX_DIM     = 16;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 5;
    localparam int CELL_W      = 12;
    localparam int AXES        = 3;

    localparam int CRD_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DXY_W       = 2 * CRD_W + 1;
    localparam int GRID_W      = CRD_W + FRAC_BITS;

    // shared multiplier: signed 34 x 33 covers both the scaling and the blends
    localparam int DIFF_W      = DATA_W + 1;
    localparam int MUL_A_W     = DIFF_W + 1;
    localparam int MUL_B_W     = DATA_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SCALED_W    = 2 * DATA_W - FRAC_BITS;

    // stream payload layout
    localparam int CELL_LSB    = 0;
    localparam int VALUE_LSB   = CELL_LSB + CELL_W;
    localparam int POS_X_LSB   = VALUE_LSB + DATA_W;
    localparam int POS_Y_LSB   = POS_X_LSB + DATA_W;
    localparam int POS_Z_LSB   = POS_Y_LSB + DATA_W;
    localparam int S_TDATA_W   = ((POS_Z_LSB + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = DATA_W;

    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam int STACK_D     = 3;
    localparam int CORNER_W    = 3;
    localparam int SC_CNT_W    = 2;
    localparam int LERP_CNT_W  = 3;
    localparam logic [LERP_CNT_W-1:0] LAST_LERP = 3'd6;

    localparam logic [DIM_W-1:0]  DIM_RESET = 5'd16;
    localparam logic [DATA_W-1:0] INV_RESET = DATA_W'(1) << FRAC_BITS;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INV_CELL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIM_X    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Y    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Z    = 3'd6;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // blend order: x x y x x y z
    function automatic axis_t lerp_axis(input logic [LERP_CNT_W-1:0] step);
        axis_t ax;
        unique case (step) inside
            3'd2, 3'd5: ax = AXIS_Y;
            3'd6:       ax = AXIS_Z;
            default:    ax = AXIS_X;
        endcase
        return ax;
    endfunction

    // highest grid coordinate in use, dimension saturated to 1..MAX_DIM
    function automatic logic [CRD_W-1:0] dim_top(input logic [DIM_W-1:0] dim);
        logic [CRD_W-1:0] top;
        if (dim == '0)
            top = '0;
        else if (int'(dim) > MAX_DIM)
            top = CRD_W'(MAX_DIM - 1);
        else
            top = CRD_W'(dim - 1'b1);
        return top;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/trilinear_grid_sampler.sv
`default_nettype none

// Trilinear grid sampler. A write item (tuser = 0) stores one Q16.16 distance in the
// 4096-entry grid store and leaves the block idle. A sample item (tuser = 1) maps the
// position into grid units as (pos - origin) * inv_cell_size, clamps each axis to
// 0..dim-1, reads the eight surrounding corners and blends them with seven truncating
// linear interpolations. A sample holds the input until its result is registered:
// one 34x33 multiplier does the three axis scalings and the seven dependent blends,
// and the single-port store gives one corner per cycle. The result waits in an
// output register, so writes are taken while it is pending. The store has no reset;
// samples must only touch cells written before. The user must change registers on
// the APB port only while no sample is in progress; the block does not enforce this.
module trilinear_grid_sampler
    import tgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_index, cell_value, pos_x, pos_y, pos_z, zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // distance
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_READ,
        S_LMUL,
        S_LADD,
        S_DONE
    } state_t;

    // configuration
    logic [DATA_W-1:0]  origin_x_reg;
    logic [DATA_W-1:0]  origin_y_reg;
    logic [DATA_W-1:0]  origin_z_reg;
    logic [DATA_W-1:0]  inv_cell_reg;
    logic [DIM_W-1:0]   dim_x_reg;
    logic [DIM_W-1:0]   dim_y_reg;
    logic [DIM_W-1:0]   dim_z_reg;
    logic               cfg_wr;

    // control
    state_t                 state_reg, state_next;
    logic [SC_CNT_W-1:0]    sc_cnt_reg, sc_cnt_next;
    logic [CORNER_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [LERP_CNT_W-1:0]  lerp_cnt_reg, lerp_cnt_next;
    logic                   pend_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]      m_tdata_reg, m_tdata_next;

    // datapath
    logic [DIFF_W-1:0]      diff_reg [AXES];
    logic                   pos_flag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [CRD_W-1:0]       crd_reg [AXES];
    logic [FRAC_BITS-1:0]   frac_reg [AXES];
    logic [DXY_W-1:0]       dxy_reg;
    logic [DATA_W-1:0]      a_reg;
    logic [DATA_W-1:0]      stack_reg [STACK_D];
    logic [DATA_W-1:0]      stack_next [STACK_D];
    logic [DATA_W-1:0]      rd_data_reg;
    logic [DATA_W-1:0]      store_mem [STORE_DEPTH];

    logic                   in_xfer;
    logic                   in_opcode;
    logic [CELL_W-1:0]      in_cell_index;
    logic [DATA_W-1:0]      in_cell_value;
    logic [DATA_W-1:0]      in_pos_x;
    logic [DATA_W-1:0]      in_pos_y;
    logic [DATA_W-1:0]      in_pos_z;
    logic                   store_we;
    logic [ADDR_W-1:0]      wr_addr;

    logic [CRD_W-1:0]       top_x, top_y, top_z;
    logic [CRD_W:0]         dx, dy;
    logic [CRD_W-1:0]       x1, y1, z1;
    logic [CRD_W-1:0]       cx, cy, cz;
    logic [ADDR_W-1:0]      rd_addr;

    logic [DIFF_W-1:0]      diff_sel;
    logic [SC_CNT_W-1:0]    cl_idx;
    logic [CRD_W-1:0]       cl_top;
    logic [SCALED_W-1:0]    scaled;
    logic [SCALED_W-1:0]    top_wide;
    logic [GRID_W-1:0]      clamped;

    logic [DATA_W-1:0]      top_op;
    logic [DATA_W-1:0]      sec_op;
    logic [DIFF_W-1:0]      blend_d;
    logic [FRAC_BITS-1:0]   frac_sel;
    logic [DATA_W-1:0]      lerp_res;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // ---------------------------------------------------------------- config port

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_cell_reg <= INV_RESET;
            dim_x_reg    <= DIM_RESET;
            dim_y_reg    <= DIM_RESET;
            dim_z_reg    <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[PADDR_W-1:2])
                REG_ORIGIN_X: origin_x_reg <= pwdata;
                REG_ORIGIN_Y: origin_y_reg <= pwdata;
                REG_ORIGIN_Z: origin_z_reg <= pwdata;
                REG_INV_CELL: inv_cell_reg <= pwdata;
                REG_DIM_X:    dim_x_reg    <= pwdata[DIM_W-1:0];
                REG_DIM_Y:    dim_y_reg    <= pwdata[DIM_W-1:0];
                REG_DIM_Z:    dim_z_reg    <= pwdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_ORIGIN_X: prdata = origin_x_reg;
            REG_ORIGIN_Y: prdata = origin_y_reg;
            REG_ORIGIN_Z: prdata = origin_z_reg;
            REG_INV_CELL: prdata = inv_cell_reg;
            REG_DIM_X:    prdata = DATA_W'(dim_x_reg);
            REG_DIM_Y:    prdata = DATA_W'(dim_y_reg);
            REG_DIM_Z:    prdata = DATA_W'(dim_z_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input side

    assign in_opcode     = s_axis_tuser;
    assign in_cell_index = s_axis_tdata[CELL_LSB +: CELL_W];
    assign in_cell_value = s_axis_tdata[VALUE_LSB +: DATA_W];
    assign in_pos_x      = s_axis_tdata[POS_X_LSB +: DATA_W];
    assign in_pos_y      = s_axis_tdata[POS_Y_LSB +: DATA_W];
    assign in_pos_z      = s_axis_tdata[POS_Z_LSB +: DATA_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign store_we      = in_xfer && (in_opcode == OP_WRITE)
                           && (int'(in_cell_index) < STORE_DEPTH);
    assign wr_addr       = ADDR_W'(in_cell_index);

    // ---------------------------------------------------------------- grid geometry

    assign top_x = dim_top(dim_x_reg);
    assign top_y = dim_top(dim_y_reg);
    assign top_z = dim_top(dim_z_reg);
    assign dx    = {1'b0, top_x} + 1'b1;
    assign dy    = {1'b0, top_y} + 1'b1;

    // upper neighbor, capped at the last grid point
    assign x1 = (crd_reg[0] == top_x) ? crd_reg[0] : crd_reg[0] + 1'b1;
    assign y1 = (crd_reg[1] == top_y) ? crd_reg[1] : crd_reg[1] + 1'b1;
    assign z1 = (crd_reg[2] == top_z) ? crd_reg[2] : crd_reg[2] + 1'b1;

    // corner order: bit 0 picks x, bit 1 picks y, bit 2 picks z
    assign cx = rd_cnt_reg[0] ? x1 : crd_reg[0];
    assign cy = rd_cnt_reg[1] ? y1 : crd_reg[1];
    assign cz = rd_cnt_reg[2] ? z1 : crd_reg[2];

    assign rd_addr = ADDR_W'(cz) * ADDR_W'(dxy_reg) + ADDR_W'(cy) * ADDR_W'(dx)
                     + ADDR_W'(cx);

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[wr_addr] <= in_cell_value;
        if (state_reg == S_READ)
            rd_data_reg <= store_mem[rd_addr];
    end

    // ---------------------------------------------------------------- scaling

    always_comb
    begin
        case (sc_cnt_reg)
            2'd0:    diff_sel = diff_reg[0];
            2'd1:    diff_sel = diff_reg[1];
            2'd2:    diff_sel = diff_reg[2];
            default: diff_sel = '0;
        endcase
    end

    // clamp of the axis whose product was formed in the cycle before
    assign cl_idx = sc_cnt_reg - 1'b1;

    always_comb
    begin
        case (axis_t'(cl_idx))
            AXIS_X:  cl_top = top_x;
            AXIS_Y:  cl_top = top_y;
            AXIS_Z:  cl_top = top_z;
            default: cl_top = top_x;
        endcase
    end

    assign scaled   = prod_reg[FRAC_BITS +: SCALED_W];
    assign top_wide = SCALED_W'({cl_top, {FRAC_BITS{1'b0}}});

    always_comb
    begin
        if (!pos_flag_reg)
            clamped = '0;
        else if (scaled > top_wide)
            clamped = {cl_top, {FRAC_BITS{1'b0}}};
        else
            clamped = scaled[GRID_W-1:0];
    end

    // ---------------------------------------------------------------- blend unit

    // a read transfer still in flight counts as the top of the stack
    assign top_op  = pend_reg ? rd_data_reg : stack_reg[0];
    assign sec_op  = pend_reg ? stack_reg[0] : stack_reg[1];
    assign blend_d = {1'b0, top_op} - {1'b0, sec_op};

    always_comb
    begin
        case (lerp_axis(lerp_cnt_reg))
            AXIS_X:  frac_sel = frac_reg[0];
            AXIS_Y:  frac_sel = frac_reg[1];
            AXIS_Z:  frac_sel = frac_reg[2];
            default: frac_sel = frac_reg[0];
        endcase
    end

    // a + ((b - a) * f >>> frac) equals the two-product form exactly
    assign lerp_res = a_reg + prod_reg[FRAC_BITS +: DATA_W];

    always_comb
    begin
        if (state_reg == S_LMUL)
        begin
            mul_a = {blend_d[DIFF_W-1], blend_d};
            mul_b = MUL_B_W'(frac_sel);
        end
        else
        begin
            mul_a = {diff_sel[DIFF_W-1], diff_sel};
            mul_b = {1'b0, inv_cell_reg};
        end
    end

    always_comb
    begin
        for (int i = 0; i < STACK_D; i++)
            stack_next[i] = stack_reg[i];
        case (state_reg)
            S_READ:
            begin
                if (pend_reg)
                begin
                    for (int i = 1; i < STACK_D; i++)
                        stack_next[i] = stack_reg[i-1];
                    stack_next[0] = rd_data_reg;
                end
            end
            S_LMUL:
            begin
                if (pend_reg)
                begin
                    for (int i = 0; i < STACK_D - 1; i++)
                        stack_next[i] = stack_reg[i+1];
                end
                else
                begin
                    for (int i = 0; i < STACK_D - 2; i++)
                        stack_next[i] = stack_reg[i+2];
                end
            end
            S_LADD:
            begin
                for (int i = 1; i < STACK_D; i++)
                    stack_next[i] = stack_reg[i-1];
                stack_next[0] = lerp_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        for (int i = 0; i < STACK_D; i++)
            stack_reg[i] <= stack_next[i];
        if (state_reg == S_LMUL)
            a_reg <= sec_op;
        if (state_reg == S_SCALE)
            pos_flag_reg <= !diff_sel[DIFF_W-1] && (diff_sel != '0);
        if (in_xfer && (in_opcode == OP_SAMPLE))
        begin
            diff_reg[0] <= {in_pos_x[DATA_W-1], in_pos_x}
                           - {origin_x_reg[DATA_W-1], origin_x_reg};
            diff_reg[1] <= {in_pos_y[DATA_W-1], in_pos_y}
                           - {origin_y_reg[DATA_W-1], origin_y_reg};
            diff_reg[2] <= {in_pos_z[DATA_W-1], in_pos_z}
                           - {origin_z_reg[DATA_W-1], origin_z_reg};
            dxy_reg     <= DXY_W'(dx) * DXY_W'(dy);
        end
        if ((state_reg == S_SCALE) && (sc_cnt_reg != '0))
        begin
            case (axis_t'(cl_idx))
                AXIS_X:
                begin
                    crd_reg[0]  <= clamped[GRID_W-1:FRAC_BITS];
                    frac_reg[0] <= clamped[FRAC_BITS-1:0];
                end
                AXIS_Y:
                begin
                    crd_reg[1]  <= clamped[GRID_W-1:FRAC_BITS];
                    frac_reg[1] <= clamped[FRAC_BITS-1:0];
                end
                AXIS_Z:
                begin
                    crd_reg[2]  <= clamped[GRID_W-1:FRAC_BITS];
                    frac_reg[2] <= clamped[FRAC_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer

    always_comb
    begin
        state_next    = state_reg;
        sc_cnt_next   = sc_cnt_reg;
        rd_cnt_next   = rd_cnt_reg;
        lerp_cnt_next = lerp_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                sc_cnt_next   = '0;
                rd_cnt_next   = '0;
                lerp_cnt_next = '0;
                if (in_xfer && (in_opcode == OP_SAMPLE))
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                sc_cnt_next = sc_cnt_reg + 1'b1;
                if (sc_cnt_reg == SC_CNT_W'(AXES))
                    state_next = S_READ;
            end
            S_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg[0])
                    state_next = S_LMUL;
            end
            S_LMUL:
            begin
                state_next = S_LADD;
            end
            S_LADD:
            begin
                lerp_cnt_next = lerp_cnt_reg + 1'b1;
                if (lerp_cnt_reg == LAST_LERP)
                    state_next = S_DONE;
                else if (lerp_axis(lerp_cnt_reg + 1'b1) == AXIS_X)
                    state_next = S_READ;
                else
                    state_next = S_LMUL;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = stack_reg[0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sc_cnt_reg   <= '0;
            rd_cnt_reg   <= '0;
            lerp_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sc_cnt_reg   <= sc_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            lerp_cnt_reg <= lerp_cnt_next;
            pend_reg     <= (state_reg == S_READ);
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### hw/rtl/tgs_checker.sv
`default_nettype none

module tgs_checker
    import tgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic in_xfer;
    logic sample_xfer;
    logic write_xfer;

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign sample_xfer = in_xfer && (s_axis_tuser == OP_SAMPLE);
    assign write_xfer  = in_xfer && (s_axis_tuser == OP_WRITE);

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a sample occupies the block after its transfer
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> !s_axis_tready)
        else $error("input taken during a sample");

    // writes never raise a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        write_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after a write");

    // a sample raises no result straight after its transfer
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early after a sample");

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (.*);

`default_nettype wire
